### src/thu_pkg.sv
// shared types and constants for the transform hierarchy update unit
package thu_pkg;

	// item function codes
	typedef enum logic [2:0] {
		FN_SET_HIER    = 3'd0,
		FN_WRITE_LOCAL = 3'd1,
		FN_UPDATE      = 3'd2,
		FN_READ_WORLD  = 3'd3,
		FN_CLEAR_HIER  = 3'd4
	} func_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MARK,
		ST_RDW,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_U_NODE_RD,
		ST_U_NODE_CHK,
		ST_U_RD_A,
		ST_U_CP,
		ST_U_RD_B,
		ST_U_MUL,
		ST_U_ACC,
		ST_U_RND,
		ST_U_WB,
		ST_U_NEXT
	} state_t;

	// controls for the multiply-accumulate unit
	typedef struct packed {
		logic load_a;
		logic mul;
		logic acc;
		logic clr;
	} mac_ctrl_t;

	localparam logic [6:0] ACTIVE_RESET = 7'd64;
	localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

endpackage

### src/transform_hierarchy_update_unit.sv
// top level of the transform hierarchy update unit
//
// Items arrive on the in channel (valid/ready); func selects set hierarchy,
// write local element, update, read world element or clear hierarchy.
// Only a world read gives a result, on the out channel (valid/ready), after
// the matrix memory read and ST_RDW; it sits in an output register, so other
// items are taken while it waits, but a further read waits for it. Set
// hierarchy writes the node memory as its beat is accepted; write local
// writes the element, then marks the node dirty; clear hierarchy rewrites
// each node entry in turn. An update walks levels 0 to the top level in use,
// each level a pass over the active nodes; each dirty node at that level
// gets each element by four multiply steps and a rounding step, all operands
// through the single matrix memory read port, then 16 write-backs; a root
// copies its local elements. The active_nodes register is written on the cfg
// channel, always ready. After reset a clearing pass zeroes both memories;
// in_ready stays low during it. A stalled receiver holds only reads.
module transform_hierarchy_update_unit #(
	parameter int NODES  = 64,
	parameter int LEVELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [5:0]         node,
	input  logic [5:0]         parent,
	input  logic               has_parent,
	input  logic [3:0]         depth,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] world_element
);
	import thu_pkg::*;

	localparam int IW  = $clog2(NODES);
	localparam int LW  = $clog2(LEVELS);
	localparam int NW  = LW + 8;
	localparam int MAW = IW + 5;
	localparam int NXW = (IW > 6) ? IW : 6;
	localparam int CW  = (IW + 1 > 7) ? IW + 1 : 7;
	localparam int DB  = NW - 1;
	localparam int PB  = NW - 2;

	state_t st_q, st_d;

	logic [6:0]        active_q;
	logic [IW-1:0]     cur_q;
	logic [LW-1:0]     lv_q, top_q;
	logic [3:0]        e_q;
	logic [1:0]        k_q;
	logic [5:0]        par_q;
	logic              root_q;
	logic              rd_ok_q;
	logic [MAW-1:0]    ic_q;
	logic              out_valid_q;
	logic signed [31:0] world_q;
	logic signed [31:0] tmp_q [16];

	logic              nw_we;
	logic [IW-1:0]     nw_waddr, nw_raddr;
	logic [NW-1:0]     nw_wdata, nw_rd;
	logic              m_we;
	logic [MAW-1:0]    m_waddr, m_raddr;
	logic [31:0]       m_wdata, m_rd;
	mac_ctrl_t         mac_ctrl;
	logic signed [31:0] mac_out;

	logic              acc;
	logic              ok;
	logic [NXW-1:0]    node_ext, par_ext, npar_ext;
	logic [IW-1:0]     in_idx, par_idx;
	logic [LW-1:0]     lvl_in, lvl_rd;
	logic [CW-1:0]     n_eff;
	logic              par_ok;

	// address and range helpers
	assign node_ext = NXW'(node);
	assign in_idx   = node_ext[IW-1:0];
	assign ok       = 32'(node) < NODES;
	assign par_ext  = NXW'(par_q);
	assign par_idx  = par_ext[IW-1:0];
	assign npar_ext = NXW'(nw_rd[PB-1 -: 6]);
	assign par_ok   = 32'(nw_rd[PB-1 -: 6]) < NODES;
	assign lvl_in   = (32'(depth) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(depth);
	assign lvl_rd   = nw_rd[LW-1:0];
	assign n_eff    = (32'(active_q) > NODES) ? CW'(NODES) : CW'(active_q);

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign world_element = world_q;

	thu_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr),
		.wdata (nw_wdata),
		.raddr (nw_raddr),
		.rdata (nw_rd)
	);

	thu_ram #(.WIDTH(32), .DEPTH(32 * NODES)) u_mat_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rd)
	);

	thu_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.din    (signed'(m_rd)),
		.result (mac_out)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
		end else begin
			st_q <= st_d;
		end
	end

	// next state, memory and mac controls
	always_comb begin
		st_d      = st_q;
		in_ready  = 1'b0;
		acc       = 1'b0;
		nw_we     = 1'b0;
		nw_waddr  = cur_q;
		nw_wdata  = '0;
		nw_raddr  = cur_q;
		m_we      = 1'b0;
		m_waddr   = '0;
		m_wdata   = '0;
		m_raddr   = '0;
		mac_ctrl  = '0;
		case (st_q)
			ST_INIT: begin
				m_we    = 1'b1;
				m_waddr = ic_q;
				if (32'(ic_q) < NODES) begin
					nw_we    = 1'b1;
					nw_waddr = ic_q[IW-1:0];
				end
				if (ic_q == MAW'(32 * NODES - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = !(out_valid_q && func == FN_READ_WORLD);
				acc      = in_valid && in_ready;
				if (acc) begin
					case (func)
						FN_SET_HIER: begin
							if (ok) begin
								nw_we    = 1'b1;
								nw_waddr = in_idx;
								nw_wdata = {1'b1, has_parent, parent, lvl_in};
							end
						end
						FN_WRITE_LOCAL: begin
							if (ok) begin
								m_we     = 1'b1;
								m_waddr  = {in_idx, row, col, 1'b0};
								m_wdata  = element;
								nw_raddr = in_idx;
								st_d     = ST_MARK;
							end
						end
						FN_UPDATE: begin
							if (n_eff != '0) begin
								st_d = ST_U_NODE_RD;
							end
						end
						FN_READ_WORLD: begin
							m_raddr = {in_idx, row, col, 1'b1};
							st_d    = ST_RDW;
						end
						FN_CLEAR_HIER: begin
							st_d = ST_CLR_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_MARK: begin
				nw_we    = 1'b1;
				nw_wdata = nw_rd | {1'b1, {(NW-1){1'b0}}};
				st_d     = ST_IDLE;
			end
			ST_RDW: begin
				st_d = ST_IDLE;
			end
			ST_CLR_RD: begin
				st_d = ST_CLR_WR;
			end
			ST_CLR_WR: begin
				nw_we    = 1'b1;
				nw_wdata = {nw_rd[DB], {(NW-1){1'b0}}};
				st_d     = (cur_q == IW'(NODES - 1)) ? ST_IDLE : ST_CLR_RD;
			end
			ST_U_NODE_RD: begin
				st_d = ST_U_NODE_CHK;
			end
			ST_U_NODE_CHK: begin
				mac_ctrl.clr = 1'b1;
				if (lvl_rd == lv_q && nw_rd[DB]) begin
					nw_we    = 1'b1;
					nw_wdata = nw_rd & ~{1'b1, {(NW-1){1'b0}}};
					st_d     = ST_U_RD_A;
				end else begin
					st_d = ST_U_NEXT;
				end
			end
			ST_U_RD_A: begin
				if (root_q) begin
					m_raddr = {cur_q, e_q, 1'b0};
					st_d    = ST_U_CP;
				end else begin
					m_raddr = {par_idx, e_q[3:2], k_q, 1'b1};
					st_d    = ST_U_RD_B;
				end
			end
			ST_U_CP: begin
				st_d = (e_q == 4'd15) ? ST_U_WB : ST_U_RD_A;
			end
			ST_U_RD_B: begin
				mac_ctrl.load_a = 1'b1;
				m_raddr = {cur_q, k_q, e_q[1:0], 1'b0};
				st_d    = ST_U_MUL;
			end
			ST_U_MUL: begin
				mac_ctrl.mul = 1'b1;
				st_d = ST_U_ACC;
			end
			ST_U_ACC: begin
				mac_ctrl.acc = 1'b1;
				st_d = (k_q == 2'd3) ? ST_U_RND : ST_U_RD_A;
			end
			ST_U_RND: begin
				mac_ctrl.clr = 1'b1;
				st_d = (e_q == 4'd15) ? ST_U_WB : ST_U_RD_A;
			end
			ST_U_WB: begin
				m_we    = 1'b1;
				m_waddr = {cur_q, e_q, 1'b1};
				m_wdata = tmp_q[e_q];
				st_d    = (e_q == 4'd15) ? ST_U_NEXT : ST_U_WB;
			end
			ST_U_NEXT: begin
				if (CW'(cur_q) + CW'(1) == n_eff && lv_q == top_q) begin
					st_d = ST_IDLE;
				end else begin
					st_d = ST_U_NODE_RD;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// control counters, config register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RESET;
			cur_q       <= '0;
			lv_q        <= '0;
			top_q       <= '0;
			e_q         <= '0;
			k_q         <= '0;
			ic_q        <= '0;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_INIT: begin
					ic_q <= ic_q + MAW'(1);
				end
				ST_IDLE: begin
					if (acc) begin
						cur_q   <= (func == FN_WRITE_LOCAL) ? in_idx : '0;
						rd_ok_q <= ok;
						lv_q    <= '0;
						top_q   <= '0;
					end
				end
				ST_RDW: begin
					out_valid_q <= 1'b1;
				end
				ST_CLR_WR: begin
					cur_q <= cur_q + IW'(1);
				end
				ST_U_NODE_CHK: begin
					if (lv_q == '0 && lvl_rd > top_q) begin
						top_q <= lvl_rd;
					end
					e_q <= '0;
					k_q <= '0;
				end
				ST_U_CP, ST_U_RND, ST_U_WB: begin
					e_q <= e_q + 4'd1;
				end
				ST_U_ACC: begin
					k_q <= k_q + 2'd1;
				end
				ST_U_NEXT: begin
					if (CW'(cur_q) + CW'(1) == n_eff) begin
						cur_q <= '0;
						lv_q  <= lv_q + LW'(1);
					end else begin
						cur_q <= cur_q + IW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers: node attributes, result buffer, read data
	always_ff @(posedge clk) begin
		if (st_q == ST_U_NODE_CHK) begin
			par_q  <= npar_ext[5:0];
			root_q <= !nw_rd[PB] || !par_ok;
		end
		if (st_q == ST_U_CP) begin
			tmp_q[e_q] <= signed'(m_rd);
		end
		if (st_q == ST_U_RND) begin
			tmp_q[e_q] <= mac_out;
		end
		if (st_q == ST_RDW) begin
			world_q <= rd_ok_q ? signed'(m_rd) : 32'sd0;
		end
	end

endmodule

### src/thu_ram.sv
// generic single-write, single-read synchronous ram with registered read
module thu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/thu_mac.sv
// q16.16 multiply-accumulate with round to nearest and saturation
module thu_mac (
	input  logic                  clk,
	input  thu_pkg::mac_ctrl_t    ctrl,
	input  logic signed [31:0]    din,
	output logic signed [31:0]    result
);
	import thu_pkg::*;

	logic signed [31:0] a_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] rnd;

	// operand, product and exact accumulator registers
	always_ff @(posedge clk) begin
		if (ctrl.load_a) begin
			a_q <= din;
		end
		if (ctrl.mul) begin
			prod_q <= a_q * din;
		end
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.acc) begin
			acc_q <= acc_q + 66'(prod_q);
		end
	end

	// round q32.32 to q16.16, ties upward, then clamp
	always_comb begin
		rnd = (acc_q + ROUND_HALF) >>> 16;
		if (rnd > SAT_HI) begin
			result = Q_MAX;
		end else if (rnd < SAT_LO) begin
			result = Q_MIN;
		end else begin
			result = rnd[31:0];
		end
	end

endmodule

### src/thu_checker.sv
// port-level checks for the transform hierarchy update unit, bound to the top
module thu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         func,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] world_element
);
	import thu_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(world_element))
		else $error("result changed while stalled");

	// a read is only taken when the output register is free
	a_read_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FN_READ_WORLD |-> !out_valid)
		else $error("read accepted over a pending result");

	// the cycle after a read beat the input is closed
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FN_READ_WORLD |=> !in_ready)
		else $error("input open while read in flight");

	// a read beat raises out_valid after the memory read and the ST_RDW state
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FN_READ_WORLD |-> ##2 out_valid)
		else $error("read result missing");

endmodule

bind transform_hierarchy_update_unit thu_checker u_thu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.func          (func),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.world_element (world_element)
);

### tb/tb_transform_hierarchy_update_unit.sv
// testbench for the transform hierarchy update unit, with an inline world matrix predictor
module tb_transform_hierarchy_update_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import thu_pkg::*;

	localparam int          NODES        = 64;
	localparam int          LEVELS       = 16;
	localparam int          CYCLE_LIMIT  = 3000000;
	localparam int          SETTLE       = 20000;
	localparam int          IDLE_PCT     = 15;
	localparam logic [2:0]  FN_SPARE_LO  = 3'd5;
	localparam logic [2:0]  FN_SPARE_HI  = 3'd7;

	typedef struct {
		logic [2:0]         fn;
		logic [5:0]         node;
		logic [5:0]         parent;
		logic               has_par;
		logic [3:0]         depth;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] elem;
		bit                 wait_drain;
	} tf_item_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [6:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic [5:0]         node;
	logic [5:0]         parent;
	logic               has_parent;
	logic [3:0]         depth;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] element;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] world_element;

	// predicted hierarchy and matrices
	logic [5:0]         m_link [NODES];
	bit                 m_present [NODES];
	logic [3:0]         m_level [NODES];
	bit                 m_dirty [NODES];
	logic signed [31:0] m_local [NODES][16];
	logic signed [31:0] m_world [NODES][16];
	logic [6:0]         m_active;

	tf_item_t           pending_items[$];
	logic signed [31:0] expected_world[$];
	tf_item_t           cur;
	int                 fails;
	int                 beats_in;
	int                 beats_out;
	int                 cycles;
	int                 hold_left;
	bit                 hold_done;

	transform_hierarchy_update_unit #(.NODES(NODES), .LEVELS(LEVELS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .node(node), .parent(parent), .has_parent(has_parent),
		.depth(depth), .row(row), .col(col), .element(element),
		.out_valid(out_valid), .out_ready(out_ready), .world_element(world_element)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// one world element: rounded, saturated dot product of parent row and local column
	function automatic logic signed [31:0] world_dot(int p, int i, int r, int c);
		logic signed [65:0] acc;
		logic signed [65:0] a;
		logic signed [65:0] b;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			a = 66'(m_world[p][r*4+k]);
			b = 66'(m_local[i][k*4+c]);
			acc = acc + a * b;
		end
		acc = (acc + ROUND_HALF) >>> 16;
		if (acc > SAT_HI)
			return Q_MAX;
		if (acc < SAT_LO)
			return Q_MIN;
		return acc[31:0];
	endfunction

	task automatic refresh_world(int i);
		logic signed [31:0] tmp [16];
		for (int e = 0; e < 16; e++)
			tmp[e] = m_present[i] ? world_dot(int'(m_link[i]), i, e / 4, e % 4)
				: m_local[i][e];
		for (int e = 0; e < 16; e++)
			m_world[i][e] = tmp[e];
	endtask

	task automatic propagate_levels();
		int n;
		int top;
		n = (int'(m_active) > NODES) ? NODES : int'(m_active);
		top = 0;
		for (int i = 0; i < n; i++)
			if (int'(m_level[i]) > top)
				top = int'(m_level[i]);
		for (int lv = 0; lv <= top; lv++)
			for (int i = 0; i < n; i++)
				if (int'(m_level[i]) == lv && m_dirty[i]) begin
					m_dirty[i] = 0;
					refresh_world(i);
				end
	endtask

	// apply one accepted item to the predicted state
	task automatic apply_item(tf_item_t it);
		case (it.fn)
			FN_SET_HIER: begin
				m_dirty[it.node]   = 1;
				m_link[it.node]    = it.parent;
				m_present[it.node] = it.has_par;
				m_level[it.node]   = it.depth;
			end
			FN_WRITE_LOCAL: begin
				m_dirty[it.node] = 1;
				m_local[it.node][it.row*4+it.col] = it.elem;
			end
			FN_UPDATE:
				propagate_levels();
			FN_READ_WORLD:
				expected_world.push_back(m_world[it.node][it.row*4+it.col]);
			FN_CLEAR_HIER:
				for (int i = 0; i < NODES; i++) begin
					m_link[i]    = '0;
					m_present[i] = 0;
					m_level[i]   = '0;
				end
			default: ;
		endcase
	endtask

	// sender: offers queued beats, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			func       <= '0;
			node       <= '0;
			parent     <= '0;
			has_parent <= 1'b0;
			depth      <= '0;
			row        <= '0;
			col        <= '0;
			element    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				apply_item(cur);
				beats_in <= beats_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0
						&& !(pending_items[0].wait_drain && expected_world.size() != 0)
						&& ((beats_in >= 250 && beats_in < 350)
							|| $urandom_range(99) >= IDLE_PCT)) begin
					cur        <= pending_items[0];
					func       <= pending_items[0].fn;
					node       <= pending_items[0].node;
					parent     <= pending_items[0].parent;
					has_parent <= pending_items[0].has_par;
					depth      <= pending_items[0].depth;
					row        <= pending_items[0].row;
					col        <= pending_items[0].col;
					element    <= pending_items[0].elem;
					in_valid   <= 1'b1;
					void'(pending_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, so the output register backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 0;
		end else if (!hold_done && beats_out >= 100) begin
			hold_left <= 500;
			hold_done <= 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				beats_out <= beats_out + 1;
				if (expected_world.size() == 0) begin
					$error("unexpected result beat, world_element %0d", world_element);
					fails++;
				end else begin
					if (world_element !== expected_world[0]) begin
						$error("world_element expected %0d actual %0d",
							expected_world[0], world_element);
						fails++;
					end
					void'(expected_world.pop_front());
				end
			end
			out_ready <= (hold_left == 0)
				&& ((beats_in >= 250 && beats_in < 350) || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_item(logic [2:0] fn, logic [5:0] nd, logic [5:0] par, logic hp,
			logic [3:0] dp, logic [1:0] r, logic [1:0] c, logic signed [31:0] el,
			bit drain);
		tf_item_t it;
		it.fn = fn; it.node = nd; it.parent = par; it.has_par = hp; it.depth = dp;
		it.row = r; it.col = c; it.elem = el; it.wait_drain = drain;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [31:0] rand_elem();
		if ($urandom_range(99) < 60)
			return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		return $urandom;
	endfunction

	// well-formed chain: hierarchy, local writes, update, reads
	task automatic add_chain();
		int          len;
		logic [5:0]  nodes [6];
		logic [5:0]  lim;
		bit          drain;
		lim = (m_active == 0 || m_active > NODES) ? 6'd63 : 6'(m_active - 1);
		len = $urandom_range(6, 2);
		drain = ($urandom_range(7) == 0);
		for (int j = 0; j < len; j++) begin
			nodes[j] = 6'($urandom_range(lim));
			add_item(FN_SET_HIER, nodes[j], (j == 0) ? 6'($urandom) : nodes[j-1],
				(j != 0) || 1'($urandom_range(1)), 4'(j + $urandom_range(2)), '0, '0, '0,
				drain && j == 0);
			for (int w = $urandom_range(4, 1); w > 0; w--)
				add_item(FN_WRITE_LOCAL, nodes[j], 6'($urandom), 1'($urandom),
					4'($urandom), 2'($urandom), 2'($urandom), rand_elem(), 1'b0);
		end
		add_item(FN_UPDATE, 6'($urandom), 6'($urandom), 1'($urandom), 4'($urandom),
			2'($urandom), 2'($urandom), $urandom, 1'b0);
		for (int k = $urandom_range(4, 2); k > 0; k--)
			add_item(FN_READ_WORLD, nodes[$urandom_range(len - 1)], 6'($urandom),
				1'($urandom), 4'($urandom), 2'($urandom), 2'($urandom), $urandom, 1'b0);
	endtask

	// random noise beat of any function
	task automatic add_noise();
		logic [2:0] fn;
		fn = 3'($urandom);
		if (fn == FN_UPDATE && $urandom_range(3) != 0)
			fn = FN_READ_WORLD;
		if (fn == FN_CLEAR_HIER && $urandom_range(3) != 0)
			fn = FN_SPARE_LO;
		add_item(fn, 6'($urandom), 6'($urandom), 1'($urandom), 4'($urandom),
			2'($urandom), 2'($urandom), $urandom, 1'b0);
	endtask

	task automatic write_active(logic [6:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_active = v;
	endtask

	task automatic drain_all();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_world.size() != 0);
		repeat (SETTLE) @(posedge clk);
		// make sure no update is still walking
		while (!in_ready) @(posedge clk);
	endtask

	// stimulus and end of run
	initial begin
		logic [6:0] settings [6];
		int         target;
		settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd17, 7'd40};
		fails = 0; beats_in = 0; beats_out = 0; cycles = 0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		m_active  = ACTIVE_RESET;
		for (int i = 0; i < NODES; i++) begin
			m_link[i] = '0; m_present[i] = 0; m_level[i] = '0; m_dirty[i] = 0;
			for (int e = 0; e < 16; e++) begin
				m_local[i][e] = '0;
				m_world[i][e] = '0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		do @(posedge clk); while (!in_ready);

		for (int ph = 0; ph < 6; ph++) begin
			write_active(settings[ph]);
			if (ph == 0) begin
				// extremes, saturation, self parent, deepest level, spare codes
				add_item(FN_SET_HIER, 6'd0, 6'd0, 1'b0, 4'd0, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_WRITE_LOCAL, 6'd0, '0, 1'b0, '0, 2'd0, 2'd0, 32'sh7fffffff,
					1'b0);
				add_item(FN_WRITE_LOCAL, 6'd0, '0, 1'b0, '0, 2'd0, 2'd1, 32'sh80000000,
					1'b0);
				add_item(FN_WRITE_LOCAL, 6'd0, '0, 1'b0, '0, 2'd1, 2'd1, 32'sh00010000,
					1'b0);
				add_item(FN_WRITE_LOCAL, 6'd0, '0, 1'b0, '0, 2'd3, 2'd3, -32'sd1, 1'b0);
				add_item(FN_SET_HIER, 6'd63, 6'd0, 1'b1, 4'd15, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_WRITE_LOCAL, 6'd63, '0, 1'b0, '0, 2'd0, 2'd0, 32'sh7fffffff,
					1'b0);
				add_item(FN_WRITE_LOCAL, 6'd63, '0, 1'b0, '0, 2'd0, 2'd1, 32'sh80000000,
					1'b0);
				add_item(FN_SET_HIER, 6'd5, 6'd5, 1'b1, 4'd3, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_WRITE_LOCAL, 6'd5, '0, 1'b0, '0, 2'd2, 2'd2, 32'sh00010000,
					1'b0);
				add_item(FN_UPDATE, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd0, '0, 1'b0, '0, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd0, '0, 1'b0, '0, 2'd0, 2'd1, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd63, '0, 1'b0, '0, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd63, '0, 1'b0, '0, 2'd0, 2'd1, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd5, '0, 1'b0, '0, 2'd2, 2'd2, '0, 1'b0);
				add_item(FN_CLEAR_HIER, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
				add_item(FN_SPARE_LO, 6'd1, 6'd2, 1'b1, 4'd9, 2'd1, 2'd2, -32'sd1, 1'b0);
				add_item(FN_SPARE_HI, 6'd63, 6'd63, 1'b1, 4'd15, 2'd3, 2'd3, '1, 1'b0);
				add_item(FN_SET_HIER, 6'd1, 6'd63, 1'b1, 4'd1, 2'd0, 2'd0, '0, 1'b0);
				add_item(FN_WRITE_LOCAL, 6'd1, '0, 1'b0, '0, 2'd3, 2'd0, 32'sh00018000,
					1'b0);
				add_item(FN_UPDATE, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
				add_item(FN_READ_WORLD, 6'd1, '0, 1'b0, '0, 2'd3, 2'd0, '0, 1'b1);
				add_item(FN_READ_WORLD, 6'd63, '0, 1'b0, '0, 2'd3, 2'd3, '0, 1'b0);
			end
			// random part of this setting: mostly chains, some noise
			target = pending_items.size() + 100;
			while (pending_items.size() < target)
				if ($urandom_range(99) < 70)
					add_chain();
				else
					add_noise();
			drain_all();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
